FILE: hw/rtl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, operation codes, pipeline records and saturation helper for
// the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int PW = 2 * DATA_WIDTH;      // product / denominator width
    localparam int SW = 2 * DATA_WIDTH + 1;  // sum of two products
    localparam int QW = DATA_WIDTH + 1;      // quotient bits kept

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic                  ovf;
        logic [DATA_WIDTH-1:0] val;
    } t_sat;

    // side data riding along the divider stages
    typedef struct packed {
        logic                  is_div;
        logic                  dz;
        logic                  re_neg;
        logic                  im_neg;
        logic                  re_pre;
        logic                  im_pre;
        logic                  nd_ovf;
        logic [DATA_WIDTH-1:0] nd_re;
        logic [DATA_WIDTH-1:0] nd_im;
    } t_side;

    localparam logic signed [SW-1:0] SAT_MAX =
        {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN =
        {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    // clamp a wide signed value to DATA_WIDTH bits
    function automatic t_sat sat_wide(input logic signed [SW-1:0] v);
        t_sat s;
        if (v > SAT_MAX) begin
            s.ovf = 1'b1;
            s.val = SAT_MAX[DATA_WIDTH-1:0];
        end else if (v < SAT_MIN) begin
            s.ovf = 1'b1;
            s.val = SAT_MIN[DATA_WIDTH-1:0];
        end else begin
            s.ovf = 1'b0;
            s.val = v[DATA_WIDTH-1:0];
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/complex_arith_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit_core
// Complex add, subtract, multiply and divide on signed Q16.16 operands with
// saturation, truncation toward zero and a divide-by-zero flag.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  request   | start / busy       | i_operation, i_a_real, i_a_imag,
//            |                    | i_b_real, i_b_imag
//  result    | o_valid (strobe)   | o_result_real, o_result_imag,
//            |                    | o_div_by_zero, o_overflow
//
//  Every request, whatever the operation, passes one product stage, one sum
//  stage, one magnitude stage, 33 restoring divider stages (one quotient bit
//  each) and one output stage between accept and strobe.
//  A new request is taken every cycle; busy stays low.
//  Reset (synchronous, active low) drops every request in flight.
//  The result is shown for exactly one cycle; the receiver cannot stall.
//
module complex_arith_unit_core
    import cau_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic signed [DATA_WIDTH-1:0] i_a_real,
    input  logic signed [DATA_WIDTH-1:0] i_a_imag,
    input  logic signed [DATA_WIDTH-1:0] i_b_real,
    input  logic signed [DATA_WIDTH-1:0] i_b_imag,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_result_real,
    output logic signed [DATA_WIDTH-1:0] o_result_imag,
    output logic                         o_div_by_zero,
    output logic                         o_overflow
);

    localparam int LAT = QW + 4;

    // never stall: every stage advances each cycle
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: six exact products, plus add/subtract sums
    // ------------------------------------------------------------------
    logic                         r_v1;
    t_op                          r_op1;
    logic signed [PW-1:0]         r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bb, r_p_cc;
    logic signed [DATA_WIDTH:0]   r_as_re1, r_as_im1;
    logic signed [DATA_WIDTH:0]   n_as_re1, n_as_im1;

    always_comb begin
        if (t_op'(i_operation) == OP_SUB) begin
            n_as_re1 = (DATA_WIDTH+1)'(i_a_real) - (DATA_WIDTH+1)'(i_b_real);
            n_as_im1 = (DATA_WIDTH+1)'(i_a_imag) - (DATA_WIDTH+1)'(i_b_imag);
        end else begin
            n_as_re1 = (DATA_WIDTH+1)'(i_a_real) + (DATA_WIDTH+1)'(i_b_real);
            n_as_im1 = (DATA_WIDTH+1)'(i_a_imag) + (DATA_WIDTH+1)'(i_b_imag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_op1    <= t_op'(i_operation);
        r_p_rr   <= PW'(i_a_real) * PW'(i_b_real);
        r_p_ii   <= PW'(i_a_imag) * PW'(i_b_imag);
        r_p_ri   <= PW'(i_a_real) * PW'(i_b_imag);
        r_p_ir   <= PW'(i_a_imag) * PW'(i_b_real);
        r_p_bb   <= PW'(i_b_real) * PW'(i_b_real);
        r_p_cc   <= PW'(i_b_imag) * PW'(i_b_imag);
        r_as_re1 <= n_as_re1;
        r_as_im1 <= n_as_im1;
    end

    // ------------------------------------------------------------------
    // Stage 2: combine products; denominator br^2 + bi^2
    // ------------------------------------------------------------------
    logic                       r_v2;
    t_op                        r_op2;
    logic signed [SW-1:0]       r_mul_re, r_mul_im, r_num_re, r_num_im;
    logic [PW-1:0]              r_den2;
    logic signed [DATA_WIDTH:0] r_as_re2, r_as_im2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_op2    <= r_op1;
        r_mul_re <= SW'(r_p_rr) - SW'(r_p_ii);
        r_mul_im <= SW'(r_p_ri) + SW'(r_p_ir);
        r_num_re <= SW'(r_p_rr) + SW'(r_p_ii);
        r_num_im <= SW'(r_p_ir) - SW'(r_p_ri);
        r_den2   <= PW'(r_p_bb) + PW'(r_p_cc);
        r_as_re2 <= r_as_re1;
        r_as_im2 <= r_as_im1;
    end

    // ------------------------------------------------------------------
    // Stage 3: finish add/sub/mul; take numerator magnitudes for divide
    // ------------------------------------------------------------------
    localparam logic signed [SW-1:0] RND = {{(SW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    logic signed [SW-1:0] n_tr_re, n_tr_im;
    logic [PW-1:0]        n_mag_re, n_mag_im;
    logic signed [SW-1:0] n_neg_re, n_neg_im;
    t_sat                 n_sat_re, n_sat_im;
    t_side                n_side0;

    always_comb begin
        // multiply scaling truncates toward zero
        n_tr_re = (r_mul_re[SW-1] ? r_mul_re + RND : r_mul_re) >>> FRAC_BITS;
        n_tr_im = (r_mul_im[SW-1] ? r_mul_im + RND : r_mul_im) >>> FRAC_BITS;
        if (r_op2 == OP_MUL) begin
            n_sat_re = sat_wide(n_tr_re);
            n_sat_im = sat_wide(n_tr_im);
        end else begin
            n_sat_re = sat_wide(SW'(r_as_re2));
            n_sat_im = sat_wide(SW'(r_as_im2));
        end
        n_neg_re = -r_num_re;
        n_neg_im = -r_num_im;
        n_mag_re = r_num_re[SW-1] ? n_neg_re[PW-1:0] : r_num_re[PW-1:0];
        n_mag_im = r_num_im[SW-1] ? n_neg_im[PW-1:0] : r_num_im[PW-1:0];

        n_side0.is_div = (r_op2 == OP_DIV);
        n_side0.dz     = (r_den2 == '0);
        n_side0.re_neg = r_num_re[SW-1];
        n_side0.im_neg = r_num_im[SW-1];
        n_side0.re_pre = 1'b0;
        n_side0.im_pre = 1'b0;
        n_side0.nd_ovf = n_sat_re.ovf || n_sat_im.ovf;
        n_side0.nd_re  = n_sat_re.val;
        n_side0.nd_im  = n_sat_im.val;
    end

    // ------------------------------------------------------------------
    // Divider: 33 restoring stages, lane 0 real, lane 1 imaginary.
    // Dividend is |N| * 2^FRAC_BITS; the top part seeds the remainder and
    // the low QW bits shift out of r_qx as quotient bits shift in.
    // ------------------------------------------------------------------
    logic              r_vd   [QW+1];
    t_side             r_side [QW+1];
    logic [PW-1:0]     r_den  [QW+1];
    logic [PW-1:0]     r_rem  [2][QW+1];
    logic [QW-1:0]     r_qx   [2][QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else begin
            r_vd[0] <= r_v2;
        end
        r_side[0]   <= n_side0;
        r_den[0]    <= r_den2;
        r_rem[0][0] <= PW'(n_mag_re >> (QW - FRAC_BITS));
        r_rem[1][0] <= PW'(n_mag_im >> (QW - FRAC_BITS));
        r_qx[0][0]  <= {n_mag_re[QW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        r_qx[1][0]  <= {n_mag_im[QW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    end

    for (genvar j = 0; j < QW; j++) begin : g_stage
        t_side n_side;

        always_comb begin
            n_side = r_side[j];
            // first stage: a seed at or above the divisor means the
            // quotient does not fit in QW bits
            if (j == 0) begin
                n_side.re_pre = (r_rem[0][j] >= r_den[j]);
                n_side.im_pre = (r_rem[1][j] >= r_den[j]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[j+1] <= 1'b0;
            end else begin
                r_vd[j+1] <= r_vd[j];
            end
            r_side[j+1] <= n_side;
            r_den[j+1]  <= r_den[j];
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [PW:0] n_try;
            logic [PW:0] n_diff;
            logic        n_ge;

            always_comb begin
                n_try  = {r_rem[l][j], r_qx[l][j][QW-1]};
                n_diff = n_try - {1'b0, r_den[j]};
                n_ge   = (n_try >= {1'b0, r_den[j]});
            end

            always_ff @(posedge i_clk) begin
                r_rem[l][j+1] <= n_ge ? n_diff[PW-1:0] : n_try[PW-1:0];
                r_qx[l][j+1]  <= {r_qx[l][j][QW-2:0], n_ge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: sign and saturate quotients, pick result by operation
    // ------------------------------------------------------------------
    localparam logic [QW-1:0] Q_POS_MAX = {2'b00, {(QW-2){1'b1}}};
    localparam logic [QW-1:0] Q_NEG_MAX = {2'b01, {(QW-2){1'b0}}};

    t_side                 w_side;
    logic                  n_q_ovf_re, n_q_ovf_im;
    logic [DATA_WIDTH-1:0] n_q_re, n_q_im;
    logic [DATA_WIDTH-1:0] n_res_re, n_res_im;
    logic                  n_dz, n_ovf;

    logic                  r_out_v;
    logic [DATA_WIDTH-1:0] r_res_re, r_res_im;
    logic                  r_dz, r_ovf;

    always_comb begin
        w_side = r_side[QW];
        n_q_ovf_re = w_side.re_pre ||
                     (w_side.re_neg ? (r_qx[0][QW] > Q_NEG_MAX) : (r_qx[0][QW] > Q_POS_MAX));
        n_q_ovf_im = w_side.im_pre ||
                     (w_side.im_neg ? (r_qx[1][QW] > Q_NEG_MAX) : (r_qx[1][QW] > Q_POS_MAX));

        if (n_q_ovf_re) begin
            n_q_re = w_side.re_neg ? SAT_MIN[DATA_WIDTH-1:0] : SAT_MAX[DATA_WIDTH-1:0];
        end else if (w_side.re_neg) begin
            n_q_re = -r_qx[0][QW][DATA_WIDTH-1:0];
        end else begin
            n_q_re = r_qx[0][QW][DATA_WIDTH-1:0];
        end
        if (n_q_ovf_im) begin
            n_q_im = w_side.im_neg ? SAT_MIN[DATA_WIDTH-1:0] : SAT_MAX[DATA_WIDTH-1:0];
        end else if (w_side.im_neg) begin
            n_q_im = -r_qx[1][QW][DATA_WIDTH-1:0];
        end else begin
            n_q_im = r_qx[1][QW][DATA_WIDTH-1:0];
        end

        if (!w_side.is_div) begin
            n_res_re = w_side.nd_re;
            n_res_im = w_side.nd_im;
            n_dz     = 1'b0;
            n_ovf    = w_side.nd_ovf;
        end else if (w_side.dz) begin
            // zero divisor: drop the quotient, flag it
            n_res_re = '0;
            n_res_im = '0;
            n_dz     = 1'b1;
            n_ovf    = 1'b0;
        end else begin
            n_res_re = n_q_re;
            n_res_im = n_q_im;
            n_dz     = 1'b0;
            n_ovf    = n_q_ovf_re || n_q_ovf_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_vd[QW];
        end
        r_res_re <= n_res_re;
        r_res_im <= n_res_im;
        r_dz     <= n_dz;
        r_ovf    <= n_ovf;
    end

    assign o_valid       = r_out_v;
    assign o_result_real = r_res_re;
    assign o_result_imag = r_res_im;
    assign o_div_by_zero = r_dz;
    assign o_overflow    = r_ovf;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_strobe_follows_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching request");

    a_dz_zero_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_by_zero) |->
            (o_result_real == '0 && o_result_imag == '0 && !o_overflow))
        else $error("divide by zero result not cleared");

    a_ovf_at_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |->
            (o_result_real == SAT_MAX[DATA_WIDTH-1:0] ||
             o_result_real == SAT_MIN[DATA_WIDTH-1:0] ||
             o_result_imag == SAT_MAX[DATA_WIDTH-1:0] ||
             o_result_imag == SAT_MIN[DATA_WIDTH-1:0]))
        else $error("overflow flagged without a saturated part");

endmodule

FILE: tb/tb_complex_arith_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arith_unit_core
// Drives directed and random complex requests into the arithmetic unit,
// predicts each result with exact wide arithmetic and checks every strobe.
// ----------------------------------------------------------------------------

// Holds the expected results, in request order, and compares each strobe
class cau_scoreboard;
    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        ovf;
    } t_res;

    t_res pending[$];
    int   errors;

    // Clamp a wide exact value to 32 bits; note saturation in ovf
    function automatic logic [31:0] clamp(input logic signed [159:0] v, inout logic ovf);
        if (v > 160'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -160'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Truncating divide toward zero on wide signed values
    function automatic logic signed [159:0] tdiv(input logic signed [159:0] n,
                                                input logic signed [159:0] d);
        logic        neg;
        logic [159:0] q;
        neg = n[159];
        q   = (neg ? -n : n) / d;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic void note_request(input cau_pkg::t_op op,
                                         input logic signed [31:0] ar, ai, br, bi);
        logic signed [159:0] xr, xi, yr, yi, re, im, den;
        t_res r;
        xr = ar; xi = ai; yr = br; yi = bi;
        r.dz = 1'b0;
        r.ovf = 1'b0;
        re = 0;
        im = 0;
        case (op)
            cau_pkg::OP_ADD: begin
                re = xr + yr; im = xi + yi;
            end
            cau_pkg::OP_SUB: begin
                re = xr - yr; im = xi - yi;
            end
            cau_pkg::OP_MUL: begin
                re = tdiv(xr * yr - xi * yi, 160'sd65536);
                im = tdiv(xr * yi + xi * yr, 160'sd65536);
            end
            default: begin
                if (br == 0 && bi == 0) r.dz = 1'b1;
                else begin
                    den = yr * yr + yi * yi;
                    re  = tdiv((xr * yr + xi * yi) * 160'sd65536, den);
                    im  = tdiv((xi * yr - xr * yi) * 160'sd65536, den);
                end
            end
        endcase
        r.re = clamp(re, r.ovf);
        r.im = clamp(im, r.ovf);
        pending.push_back(r);
    endfunction

    function automatic void report(input string what, input logic [31:0] got, exp_v);
        errors++;
        $display("mismatch %s: got %h, wanted %h", what, got, exp_v);
    endfunction

    function automatic void check_result(input logic [31:0] re, im, input logic dz, ovf);
        t_res e;
        if (pending.size() == 0) begin
            report("unexpected strobe", 0, 0);
            return;
        end
        e = pending.pop_front();
        if (re !== e.re) report("result_real", re, e.re);
        if (im !== e.im) report("result_imag", im, e.im);
        if (dz !== e.dz) report("div_by_zero", dz, e.dz);
        if (ovf !== e.ovf) report("overflow", ovf, e.ovf);
    endfunction
endclass

module tb_complex_arith_unit_core;
    import cau_pkg::*;

    localparam int LATENCY = 37;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_operation = OP_ADD;
    logic signed [31:0] i_a_real = 0, i_a_imag = 0, i_b_real = 0, i_b_imag = 0;
    logic        o_valid;
    logic signed [31:0] o_result_real, o_result_imag;
    logic        o_div_by_zero, o_overflow;

    cau_scoreboard sb = new();
    bit quiet_tail = 0;

    always #5 i_clk = ~i_clk;

    complex_arith_unit_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_a_real(i_a_real), .i_a_imag(i_a_imag),
        .i_b_real(i_b_real), .i_b_imag(i_b_imag), .o_valid(o_valid),
        .o_result_real(o_result_real), .o_result_imag(o_result_imag),
        .o_div_by_zero(o_div_by_zero), .o_overflow(o_overflow)
    );

    // Sample the result side on every edge; results cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_result_real, o_result_imag, o_div_by_zero, o_overflow);
    end

    // Present one request, sometimes after a random idle gap, and hold it until the unit accepts it
    task automatic send_request(input t_op op, input logic [31:0] ar, ai, br, bi);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_a_real    <= ar;
        i_a_imag    <= ai;
        i_b_real    <= br;
        i_b_imag    <= bi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_request(op, ar, ai, br, bi);
    endtask

    // Pick an operand: extremes, small values, or full-range noise
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            4, 5: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] br, bi;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each operation, extremes, zero divisor, saturation
        for (int op = 0; op < 4; op++) begin
            send_request(t_op'(op), 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
            send_request(t_op'(op), 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
            send_request(t_op'(op), 32'h0003_0000, 32'hfffe_0000, 32'h0001_8000, 32'h0);
            send_request(t_op'(op), 32'hffff_ffff, 32'h0000_0001, 32'h0, 32'h0);
        end
        send_request(OP_DIV, 32'h0001_0000, 32'h0, 32'h0000_0001, 32'h0);
        send_request(OP_DIV, 32'hffff_ffff, 32'h0, 32'h0003_0000, 32'h0);
        send_request(OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0);
        send_request(OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);

        // Pause until the pipeline is empty before the random part
        start <= 1'b0;
        drain();

        for (int n = 0; n < 1950; n++) begin
            if (n == 1700) quiet_tail = 1;
            br = pick_operand();
            bi = pick_operand();
            if ($urandom_range(0, 15) == 0) begin
                br = 0; bi = 0;
            end
            send_request(t_op'($urandom_range(0, 3)), pick_operand(), pick_operand(), br, bi);
        end
        start <= 1'b0;
        drain();
        repeat (LATENCY + 5) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: complex_arith_unit_core.f
hw/rtl/cau_pkg.sv
hw/rtl/complex_arith_unit_core.sv
tb/tb_complex_arith_unit_core.sv
